// ===== rtl/sapu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sapu_pkg;

   localparam int TIME_BITS     = 32;
   localparam int COUNTER_BITS  = 32;
   localparam int FRAC_BITS     = 15;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_HOLD    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FADE    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RESYNC  = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_MAGIC   = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_VERSION = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH  = 3'd5;

   localparam logic [15:0] HOLD_RESET    = 16'd400;
   localparam logic [15:0] FADE_RESET    = 16'd600;
   localparam logic [15:0] RESYNC_RESET  = 16'd1000;
   localparam logic [31:0] MAGIC_RESET   = 32'h5243_4A56;
   localparam logic [7:0]  VERSION_RESET = 8'd1;
   localparam logic [6:0]  LENGTH_RESET  = 7'd20;

   localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
   localparam logic [15:0] FULL_Q15  = 16'h8000;

   localparam logic CMD_TICK = 1'b0;

   localparam int HELD_BIT    = 0;
   localparam int COOLING_BIT = 3;

   localparam logic [2:0] STATUS_NONE   = 3'd0;
   localparam logic [2:0] STATUS_ACCEPT = 3'd1;
   localparam logic [2:0] STATUS_RESYNC = 3'd2;
   localparam logic [2:0] STATUS_DROP   = 3'd3;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_BAD   = 2'd2;
   localparam logic [1:0] KIND_GOOD  = 2'd3;

   typedef struct packed {
      logic [15:0] hold;
      logic [15:0] fade;
      logic [15:0] resync;
      logic [31:0] magic;
      logic [7:0]  version;
      logic [6:0]  length;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] seq;
      logic [31:0] charge;
      logic [31:0] burst;
      logic [15:0] active;
      logic [15:0] cooldown;
      logic        held;
      logic        cooling;
   } item_type;

   function automatic logic [31:0] clamp_unit(input logic [31:0] bits);
      logic nan;
      nan = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
      if (bits[31] || nan) begin
         return 32'd0;
      end else if (bits > ONE_BITS) begin
         return ONE_BITS;
      end else begin
         return bits;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sapu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sapu_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [6:0]  packet_length;
   logic [31:0] magic_word;
   logic [7:0]  version_byte;
   logic [7:0]  flag_byte;
   logic [15:0] sequence_req;
   logic [31:0] charge_bits;
   logic [31:0] burst_bits;
   logic [15:0] active_count;
   logic [15:0] cooldown_centis;

   modport source (
      output valid, command, packet_length, magic_word, version_byte, flag_byte,
             sequence_req, charge_bits, burst_bits, active_count, cooldown_centis,
      input  ready
   );
   modport sink (
      input  valid, command, packet_length, magic_word, version_byte, flag_byte,
             sequence_req, charge_bits, burst_bits, active_count, cooldown_centis,
      output ready
   );
endinterface

interface sapu_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] charge_out;
   logic [31:0] burst_out;
   logic [15:0] active_out;
   logic [15:0] cooldown_out;
   logic        held_out;
   logic        cooling_out;
   logic [15:0] freshness;
   logic [31:0] dropped_total;
   logic [31:0] accepted_total;
   logic [31:0] resync_total;

   modport source (
      output valid, status, charge_out, burst_out, active_out, cooldown_out,
             held_out, cooling_out, freshness, dropped_total, accepted_total,
             resync_total,
      input  ready
   );
   modport sink (
      input  valid, status, charge_out, burst_out, active_out, cooldown_out,
             held_out, cooling_out, freshness, dropped_total, accepted_total,
             resync_total,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/sapu_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapu_regs import sapu_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [REG_IDX_BITS-1:0] idx;
   logic                    wr_en;

   assign idx    = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_HOLD:    cfg_in.hold    = pwdata[15:0];
            REG_FADE:    cfg_in.fade    = pwdata[15:0];
            REG_RESYNC:  cfg_in.resync  = pwdata[15:0];
            REG_MAGIC:   cfg_in.magic   = pwdata[31:0];
            REG_VERSION: cfg_in.version = pwdata[7:0];
            REG_LENGTH:  cfg_in.length  = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_HOLD:    prdata = 32'(cfg_ff.hold);
         REG_FADE:    prdata = 32'(cfg_ff.fade);
         REG_RESYNC:  prdata = 32'(cfg_ff.resync);
         REG_MAGIC:   prdata = cfg_ff.magic;
         REG_VERSION: prdata = 32'(cfg_ff.version);
         REG_LENGTH:  prdata = 32'(cfg_ff.length);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold    <= HOLD_RESET;
         cfg_ff.fade    <= FADE_RESET;
         cfg_ff.resync  <= RESYNC_RESET;
         cfg_ff.magic   <= MAGIC_RESET;
         cfg_ff.version <= VERSION_RESET;
         cfg_ff.length  <= LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sapu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapu_front import sapu_pkg::*; (
   sapu_req_if.sink     req_ch,
   input  cfg_type      cfg,
   input  wire logic    queue_full,
   output logic         push,
   output item_type     item
);

   logic hdr_ok;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   assign hdr_ok = (req_ch.packet_length == cfg.length) &&
                   (req_ch.magic_word    == cfg.magic)  &&
                   (req_ch.version_byte  == cfg.version);

   always_comb begin
      priority if (req_ch.command == CMD_TICK) begin
         item.kind = KIND_TICK;
      end else if (req_ch.packet_length == 7'd0) begin
         item.kind = KIND_EMPTY;
      end else if (hdr_ok) begin
         item.kind = KIND_GOOD;
      end else begin
         item.kind = KIND_BAD;
      end
      item.seq      = req_ch.sequence_req;
      item.charge   = clamp_unit(req_ch.charge_bits);
      item.burst    = clamp_unit(req_ch.burst_bits);
      item.active   = req_ch.active_count;
      item.cooldown = req_ch.cooldown_centis;
      item.held     = req_ch.flag_byte[HELD_BIT];
      item.cooling  = req_ch.flag_byte[COOLING_BIT];
   end

endmodule

`default_nettype wire

// ===== rtl/sapu_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapu_fifo import sapu_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   input  wire logic pop,
   output logic      not_empty,
   output item_type  head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sapu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapu_back import sapu_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  cfg_type     cfg,
   input  wire logic   not_empty,
   input  item_type    head,
   output logic        pop,
   sapu_rsp_if.source  rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FRESH = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam int AGE_BITS  = TIME_BITS + 1;
   localparam int STEP_BITS = $clog2(FRAC_BITS);

   logic [1:0]              state_ff, state_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [TIME_BITS-1:0]    last_ff, last_in;
   logic                    link_ff, link_in;
   logic [15:0]             seq_ff, seq_in;
   logic [31:0]             charge_ff, charge_in;
   logic [31:0]             burst_ff, burst_in;
   logic [15:0]             active_ff, active_in;
   logic [15:0]             cooldown_ff, cooldown_in;
   logic                    held_ff, held_in;
   logic                    cooling_ff, cooling_in;
   logic [COUNTER_BITS-1:0] drop_ff, drop_in;
   logic [COUNTER_BITS-1:0] accept_ff, accept_in;
   logic [COUNTER_BITS-1:0] resync_cnt_ff, resync_cnt_in;
   logic [2:0]              status_ff, status_in;
   logic [15:0]             fresh_ff, fresh_in;
   logic [15:0]             rem_ff, rem_in;
   logic [FRAC_BITS-1:0]    quot_ff, quot_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    out_valid_ff, out_valid_in;

   logic [TIME_BITS-1:0]    age;
   logic [AGE_BITS-1:0]     age_ext;
   logic [AGE_BITS-1:0]     end_ext;
   logic                    resync;
   logic [15:0]             seq_diff;
   logic                    seq_newer;
   logic [16:0]             rem_shift;
   logic                    rem_ge;
   logic                    load_out;

   assign pop       = (state_ff == ST_IDLE) && not_empty;
   assign age       = time_ff - last_ff;
   assign age_ext   = AGE_BITS'(age);
   assign end_ext   = AGE_BITS'(cfg.hold) + AGE_BITS'(cfg.fade);
   assign resync    = !link_ff || (age > TIME_BITS'(cfg.resync));
   assign seq_diff  = head.seq - seq_ff;
   assign seq_newer = (seq_diff != 16'd0) && !seq_diff[15];
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, cfg.fade};
   assign load_out  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      last_in       = last_ff;
      link_in       = link_ff;
      seq_in        = seq_ff;
      charge_in     = charge_ff;
      burst_in      = burst_ff;
      active_in     = active_ff;
      cooldown_in   = cooldown_ff;
      held_in       = held_ff;
      cooling_in    = cooling_ff;
      drop_in       = drop_ff;
      accept_in     = accept_ff;
      resync_cnt_in = resync_cnt_ff;
      status_in     = status_ff;
      fresh_in      = fresh_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               state_in  = ST_FRESH;
               status_in = STATUS_NONE;
               unique case (head.kind)
                  KIND_TICK: begin
                     if (time_ff != '1) begin
                        time_in = time_ff + 1'b1;
                     end
                  end
                  KIND_EMPTY: ;
                  KIND_BAD: begin
                     drop_in   = drop_ff + 1'b1;
                     status_in = STATUS_DROP;
                  end
                  KIND_GOOD: begin
                     if (!resync && !seq_newer) begin
                        drop_in   = drop_ff + 1'b1;
                        status_in = STATUS_DROP;
                     end else begin
                        seq_in      = head.seq;
                        charge_in   = head.charge;
                        burst_in    = head.burst;
                        active_in   = head.active;
                        cooldown_in = head.cooldown;
                        held_in     = head.held;
                        cooling_in  = head.cooling;
                        last_in     = time_ff;
                        link_in     = 1'b1;
                        accept_in   = accept_ff + 1'b1;
                        if (resync) begin
                           resync_cnt_in = resync_cnt_ff + 1'b1;
                           status_in     = STATUS_RESYNC;
                        end else begin
                           status_in = STATUS_ACCEPT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FRESH: begin
            step_in = '0;
            quot_in = '0;
            priority if (!link_ff) begin
               fresh_in = 16'd0;
               state_in = ST_DONE;
            end else if (age <= TIME_BITS'(cfg.hold)) begin
               fresh_in = FULL_Q15;
               state_in = ST_DONE;
            end else if (age_ext >= end_ext) begin
               fresh_in = 16'd0;
               state_in = ST_DONE;
            end else begin
               rem_in   = 16'(end_ext - age_ext);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? 16'(rem_shift - {1'b0, cfg.fade}) : rem_shift[15:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], rem_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(FRAC_BITS - 1)) begin
               fresh_in = 16'({quot_ff[FRAC_BITS-2:0], rem_ge});
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_ff       <= '0;
         last_ff       <= '0;
         link_ff       <= 1'b0;
         seq_ff        <= '0;
         charge_ff     <= '0;
         burst_ff      <= '0;
         active_ff     <= '0;
         cooldown_ff   <= '0;
         held_ff       <= 1'b0;
         cooling_ff    <= 1'b0;
         drop_ff       <= '0;
         accept_ff     <= '0;
         resync_cnt_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_ff       <= time_in;
         last_ff       <= last_in;
         link_ff       <= link_in;
         seq_ff        <= seq_in;
         charge_ff     <= charge_in;
         burst_ff      <= burst_in;
         active_ff     <= active_in;
         cooldown_ff   <= cooldown_in;
         held_ff       <= held_in;
         cooling_ff    <= cooling_in;
         drop_ff       <= drop_in;
         accept_ff     <= accept_in;
         resync_cnt_ff <= resync_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      fresh_ff  <= fresh_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ch.status         <= status_ff;
         rsp_ch.charge_out     <= charge_ff;
         rsp_ch.burst_out      <= burst_ff;
         rsp_ch.active_out     <= active_ff;
         rsp_ch.cooldown_out   <= cooldown_ff;
         rsp_ch.held_out       <= held_ff;
         rsp_ch.cooling_out    <= cooling_ff;
         rsp_ch.freshness      <= fresh_ff;
         rsp_ch.dropped_total  <= 32'(drop_ff);
         rsp_ch.accepted_total <= 32'(accept_ff);
         rsp_ch.resync_total   <= 32'(resync_cnt_ff);
      end
   end

   assign rsp_ch.valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/sequenced_packet_acceptor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_ch    in         valid/ready          command, packet fields, levels, counts
// rsp_ch    out        valid/ready          status, latched fields, freshness, totals
// csr_*     in/out     APB write/read       six config registers at 4*index
//
// The back end takes one word at a time through idle, freshness and done, adding a
// divide state in the fade window: a restoring divider, one quotient bit per cycle.
// The front classifies and clamps in the cycle the word is taken, into a 2-entry queue.
// Synchronous reset clears all link state and counters and loads register defaults.
// The result register holds while rsp_ch.ready is low; requests keep flowing into
// the queue until it fills.

module sequenced_packet_acceptor_unit import sapu_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   sapu_req_if.sink                      req_ch,
   sapu_rsp_if.source                    rsp_ch,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type  cfg;
   item_type push_item;
   item_type head;
   logic     push;
   logic     pop;
   logic     full;
   logic     not_empty;

   sapu_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sapu_front u_front (
      .req_ch     (req_ch),
      .cfg        (cfg),
      .queue_full (full),
      .push       (push),
      .item       (push_item)
   );

   sapu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   sapu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/sapu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapu_checker import sapu_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [15:0] rsp_freshness,
   input wire logic [31:0] rsp_accepted_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_freshness) && $stable(rsp_accepted_total))
      else $error("result dropped or changed while stalled");

   a_accept_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ACCEPT || rsp_status == STATUS_RESYNC)
         |-> rsp_freshness == FULL_Q15)
      else $error("accepted packet without full freshness");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_DROP)
      else $error("status code out of range");

   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_freshness <= FULL_Q15)
      else $error("freshness above full scale");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sequenced_packet_acceptor_unit sapu_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_freshness      (rsp_ch.freshness),
   .rsp_accepted_total (rsp_ch.accepted_total)
);

`default_nettype wire

// ===== dv/sapu_link_checker.sv =====
`timescale 1ns / 1ps

module sapu_link_checker import sapu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   sapu_req_if                      req_ch,
   sapu_rsp_if                      rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       mismatches,
   output int                       words_pending,
   output int                       results_checked
);

   typedef struct packed {
      logic [2:0]              status;
      logic [31:0]             charge;
      logic [31:0]             burst;
      logic [15:0]             active;
      logic [15:0]             cooldown;
      logic                    held;
      logic                    cooling;
      logic [15:0]             fresh;
      logic [COUNTER_BITS-1:0] drops;
      logic [COUNTER_BITS-1:0] accepts;
      logic [COUNTER_BITS-1:0] resyncs;
   } outcome_type;

   cfg_type                 settings;
   logic [TIME_BITS-1:0]    now_ticks;
   logic [TIME_BITS-1:0]    last_accept_tick;
   logic                    seen_accept;
   logic                    seq_known;
   logic [15:0]             last_seq;
   logic [31:0]             charge_q;
   logic [31:0]             burst_q;
   logic [15:0]             active_q;
   logic [15:0]             cooldown_q;
   logic                    held_q;
   logic                    cooling_q;
   logic [COUNTER_BITS-1:0] drops;
   logic [COUNTER_BITS-1:0] accepts;
   logic [COUNTER_BITS-1:0] resyncs;
   outcome_type             outcomes[$];
   int                      fail_count = 0;
   int                      checked_count = 0;

   // negative, minus zero and NaN go to zero; anything above one saturates
   function automatic logic [31:0] clamped_level(input logic [31:0] bits);
      if (bits[31] || bits[30:0] > 31'h7F80_0000) begin
         return '0;
      end
      return (bits > ONE_BITS) ? ONE_BITS : bits;
   endfunction

   function automatic logic seq_advances(input logic [15:0] fresh, input logic [15:0] prior);
      logic [15:0] delta;
      delta = fresh - prior;
      return (delta != '0) && !delta[15];
   endfunction

   function automatic logic [15:0] link_freshness();
      logic [TIME_BITS-1:0] age;
      logic [TIME_BITS:0]   window;
      logic [63:0]          scaled;
      if (!seen_accept) begin
         return '0;
      end
      age    = now_ticks - last_accept_tick;
      window = (TIME_BITS+1)'(settings.hold) + (TIME_BITS+1)'(settings.fade);
      if (age <= TIME_BITS'(settings.hold)) begin
         return FULL_Q15;
      end
      if ((TIME_BITS+1)'(age) >= window) begin
         return '0;
      end
      scaled = 64'(window - (TIME_BITS+1)'(age)) << FRAC_BITS;
      return 16'(scaled / 64'(settings.fade));
   endfunction

   task automatic predict_word(output outcome_type o);
      logic [2:0] status;
      logic       resync;
      status = STATUS_NONE;
      if (req_ch.command == CMD_TICK) begin
         if (now_ticks != '1) begin
            now_ticks = now_ticks + 1'b1;
         end
      end else if (req_ch.packet_length != '0) begin
         resync = !seen_accept ||
                  (now_ticks - last_accept_tick) > TIME_BITS'(settings.resync);
         if (req_ch.packet_length != settings.length ||
             req_ch.magic_word != settings.magic ||
             req_ch.version_byte != settings.version ||
             (!resync && seq_known && !seq_advances(req_ch.sequence_req, last_seq))) begin
            drops  = drops + 1'b1;
            status = STATUS_DROP;
         end else begin
            if (resync) begin
               resyncs = resyncs + 1'b1;
            end
            last_seq         = req_ch.sequence_req;
            seq_known        = 1'b1;
            charge_q         = clamped_level(req_ch.charge_bits);
            burst_q          = clamped_level(req_ch.burst_bits);
            active_q         = req_ch.active_count;
            cooldown_q       = req_ch.cooldown_centis;
            held_q           = req_ch.flag_byte[HELD_BIT];
            cooling_q        = req_ch.flag_byte[COOLING_BIT];
            last_accept_tick = now_ticks;
            seen_accept      = 1'b1;
            accepts          = accepts + 1'b1;
            status           = resync ? STATUS_RESYNC : STATUS_ACCEPT;
         end
      end
      o.status   = status;
      o.charge   = charge_q;
      o.burst    = burst_q;
      o.active   = active_q;
      o.cooldown = cooldown_q;
      o.held     = held_q;
      o.cooling  = cooling_q;
      o.fresh    = link_freshness();
      o.drops    = drops;
      o.accepts  = accepts;
      o.resyncs  = resyncs;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: %s mismatch, got %0h, want %0h", $realtime, name, got, want);
         end
      end
   endtask

   task automatic compare_result(input outcome_type want);
      check_field("status", 32'(rsp_ch.status), 32'(want.status));
      check_field("charge_out", rsp_ch.charge_out, want.charge);
      check_field("burst_out", rsp_ch.burst_out, want.burst);
      check_field("active_out", 32'(rsp_ch.active_out), 32'(want.active));
      check_field("cooldown_out", 32'(rsp_ch.cooldown_out), 32'(want.cooldown));
      check_field("held_out", 32'(rsp_ch.held_out), 32'(want.held));
      check_field("cooling_out", 32'(rsp_ch.cooling_out), 32'(want.cooling));
      check_field("freshness", 32'(rsp_ch.freshness), 32'(want.fresh));
      check_field("dropped_total", rsp_ch.dropped_total, 32'(want.drops));
      check_field("accepted_total", rsp_ch.accepted_total, 32'(want.accepts));
      check_field("resync_total", rsp_ch.resync_total, 32'(want.resyncs));
   endtask

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         settings         = '{hold: HOLD_RESET, fade: FADE_RESET, resync: RESYNC_RESET,
                              magic: MAGIC_RESET, version: VERSION_RESET,
                              length: LENGTH_RESET};
         now_ticks        = '0;
         last_accept_tick = '0;
         seen_accept      = 1'b0;
         seq_known        = 1'b0;
         last_seq         = '0;
         charge_q         = '0;
         burst_q          = '0;
         active_q         = '0;
         cooldown_q       = '0;
         held_q           = 1'b0;
         cooling_q        = 1'b0;
         drops            = '0;
         accepts          = '0;
         resyncs          = '0;
         outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2 +: REG_IDX_BITS])
               REG_HOLD:    settings.hold    = csr_pwdata[15:0];
               REG_FADE:    settings.fade    = csr_pwdata[15:0];
               REG_RESYNC:  settings.resync  = csr_pwdata[15:0];
               REG_MAGIC:   settings.magic   = csr_pwdata[31:0];
               REG_VERSION: settings.version = csr_pwdata[7:0];
               REG_LENGTH:  settings.length  = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_word(o);
            outcomes.push_back(o);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked_count++;
            if (outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result word with nothing outstanding", $realtime);
               end
            end else begin
               compare_result(outcomes.pop_front());
            end
         end
      end
      mismatches      <= fail_count;
      words_pending   <= outcomes.size();
      results_checked <= checked_count;
   end

endmodule

// ===== dv/sequenced_packet_acceptor_unit_tb.sv =====
`timescale 1ns / 1ps

module sequenced_packet_acceptor_unit_tb;
   import sapu_pkg::*;

   localparam logic CMD_PACKET = ~CMD_TICK;

   typedef struct {
      logic        cmd;
      logic [6:0]  len;
      logic [31:0] magic;
      logic [7:0]  ver;
      logic [7:0]  flags;
      logic [15:0] seq;
      logic [31:0] charge;
      logic [31:0] burst;
      logic [15:0] active;
      logic [15:0] cooldown;
   } word_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   logic                     sink_ready  = 1'b0;
   logic                     idling      = 1'b0;
   int                       mismatches;
   int                       words_pending;
   int                       results_checked;
   int                       ticks_sent    = 0;
   int                       packets_sent  = 0;
   int                       settings_used = 0;
   cfg_type                  cfg;
   logic [15:0]              newest_seq;

   sapu_req_if req_ch();
   sapu_rsp_if rsp_ch();

   assign rsp_ch.ready = sink_ready;

   sequenced_packet_acceptor_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sapu_link_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatches      (mismatches),
      .words_pending   (words_pending),
      .results_checked (results_checked)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      sink_ready <= !idling || ($urandom_range(99) >= 14);
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] level_bits();
      case ($urandom_range(8))
         0:       return '0;
         1:       return {1'b1, 31'($urandom)};
         2:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
         3:       return {1'b0, 8'hFF, 23'h0};
         4:       return ONE_BITS;
         5:       return ONE_BITS + 1'b1;
         6:       return ONE_BITS - 1'b1;
         7:       return $urandom;
         default: return $urandom_range(ONE_BITS);
      endcase
   endfunction

   function automatic word_type noise_word();
      word_type w;
      w.cmd      = 1'($urandom_range(1));
      w.len      = 7'($urandom_range(64));
      w.magic    = $urandom;
      w.ver      = 8'($urandom);
      w.flags    = 8'($urandom);
      w.seq      = 16'($urandom);
      w.charge   = $urandom;
      w.burst    = $urandom;
      w.active   = 16'($urandom);
      w.cooldown = 16'($urandom);
      return w;
   endfunction

   function automatic word_type tick_word();
      word_type w;
      w     = noise_word();
      w.cmd = CMD_TICK;
      return w;
   endfunction

   function automatic word_type good_packet(input logic [15:0] seq);
      word_type w;
      w          = noise_word();
      w.cmd      = CMD_PACKET;
      w.len      = cfg.length;
      w.magic    = cfg.magic;
      w.ver      = cfg.version;
      w.seq      = seq;
      w.charge   = level_bits();
      w.burst    = level_bits();
      return w;
   endfunction

   // mostly advance a little, sometimes repeat, go back, jump half the ring or pick any value
   function automatic logic [15:0] next_seq();
      logic [15:0] s;
      logic [15:0] delta;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         s = newest_seq + 16'($urandom_range(1, 3));
      end else if (pick < 80) begin
         s = newest_seq;
      end else if (pick < 88) begin
         s = newest_seq - 16'($urandom_range(1, 200));
      end else if (pick < 93) begin
         s = newest_seq + 16'h8000;
      end else begin
         s = 16'($urandom);
      end
      delta = s - newest_seq;
      if (delta != '0 && !delta[15]) begin
         newest_seq = s;
      end
      return s;
   endfunction

   function automatic word_type broken_packet();
      word_type w;
      w = good_packet(next_seq());
      case ($urandom_range(2))
         0: begin
            do begin
               w.len = 7'($urandom_range(1, 64));
            end while (w.len == cfg.length);
         end
         1:       w.magic = w.magic ^ (32'd1 << $urandom_range(31));
         default: w.ver   = w.ver ^ (8'd1 << $urandom_range(7));
      endcase
      return w;
   endfunction

   task automatic send_word(input word_type w);
      logic taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (idling && $urandom_range(99) < 14) begin
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid           <= 1'b1;
            req_ch.command         <= w.cmd;
            req_ch.packet_length   <= w.len;
            req_ch.magic_word      <= w.magic;
            req_ch.version_byte    <= w.ver;
            req_ch.flag_byte       <= w.flags;
            req_ch.sequence_req    <= w.seq;
            req_ch.charge_bits     <= w.charge;
            req_ch.burst_bits      <= w.burst;
            req_ch.active_count    <= w.active;
            req_ch.cooldown_centis <= w.cooldown;
         end
         @(posedge clock);
         taken = req_ch.valid && req_ch.ready;
      end
      if (w.cmd == CMD_TICK) begin
         ticks_sent++;
      end else begin
         packets_sent++;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (words_pending != 0);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_settings(input cfg_type c);
      drain();
      csr_write(REG_HOLD, 32'(c.hold));
      csr_write(REG_FADE, 32'(c.fade));
      csr_write(REG_RESYNC, 32'(c.resync));
      csr_write(REG_MAGIC, c.magic);
      csr_write(REG_VERSION, 32'(c.version));
      csr_write(REG_LENGTH, 32'(c.length));
      cfg = c;
      settings_used++;
   endtask

   function automatic cfg_type short_window_cfg();
      cfg_type c;
      c.hold    = 16'($urandom_range(40));
      c.fade    = 16'($urandom_range(1, 50));
      c.resync  = 16'($urandom_range(80));
      c.magic   = $urandom;
      c.version = 8'($urandom);
      c.length  = 7'($urandom_range(1, 64));
      return c;
   endfunction

   task automatic random_phase(input int count);
      int       sent;
      int       pick;
      int       run_len;
      word_type w;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            run_len = ($urandom_range(19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            repeat (run_len) send_word(tick_word());
            sent += run_len;
         end else begin
            if (pick < 80) begin
               w = good_packet(next_seq());
            end else if (pick < 90) begin
               w = broken_packet();
            end else if (pick < 95) begin
               w     = noise_word();
               w.cmd = CMD_PACKET;
               w.len = '0;
            end else begin
               w = noise_word();
            end
            send_word(w);
            sent++;
         end
      end
   endtask

   initial begin
      word_type w;
      cfg_type  c;
      req_ch.valid           = 1'b0;
      req_ch.command         = CMD_TICK;
      req_ch.packet_length   = '0;
      req_ch.magic_word      = '0;
      req_ch.version_byte    = '0;
      req_ch.flag_byte       = '0;
      req_ch.sequence_req    = '0;
      req_ch.charge_bits     = '0;
      req_ch.burst_bits      = '0;
      req_ch.active_count    = '0;
      req_ch.cooldown_centis = '0;
      cfg        = '{hold: HOLD_RESET, fade: FADE_RESET, resync: RESYNC_RESET,
                     magic: MAGIC_RESET, version: VERSION_RESET, length: LENGTH_RESET};
      newest_seq = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_word(tick_word());
      w     = noise_word();
      w.cmd = CMD_PACKET;
      w.len = '0;
      send_word(w);
      w       = good_packet(16'hFFFF);
      w.magic = ~cfg.magic;
      send_word(w);
      w     = good_packet(16'hFFFF);
      w.ver = cfg.version ^ 8'h80;
      send_word(w);
      w     = good_packet(16'hFFFF);
      w.len = 7'd64;
      send_word(w);
      w          = good_packet(16'hFFFF);
      w.charge   = 32'h8000_0000;
      w.burst    = 32'h7FC0_0001;
      w.flags    = 8'hFF;
      w.active   = '1;
      w.cooldown = '1;
      send_word(w);
      send_word(good_packet(16'hFFFF));
      w        = good_packet(16'h0000);
      w.charge = 32'h7F80_0000;
      w.burst  = ONE_BITS;
      w.flags  = 8'h09;
      send_word(w);
      send_word(good_packet(16'h8000));
      w        = good_packet(16'h7FFF);
      w.charge = ONE_BITS + 1'b1;
      w.burst  = 32'hBF80_0000;
      w.flags  = 8'hF6;
      send_word(w);
      send_word(good_packet(16'h7FFE));
      w          = good_packet(16'h8000);
      w.charge   = ONE_BITS - 1'b1;
      w.burst    = '0;
      w.active   = '0;
      w.cooldown = '0;
      w.flags    = 8'h01;
      send_word(w);

      // walk through hold, fade and expiry, then an old sequence before and after resync
      load_settings('{hold: 16'd2, fade: 16'd3, resync: 16'd6, magic: MAGIC_RESET,
                      version: VERSION_RESET, length: LENGTH_RESET});
      repeat (5) send_word(tick_word());
      send_word(good_packet(16'h7000));
      repeat (2) send_word(tick_word());
      send_word(good_packet(16'h7000));
      newest_seq = 16'h7000;

      load_settings(short_window_cfg());
      random_phase(350);

      idling <= 1'b1;
      load_settings(short_window_cfg());
      random_phase(350);

      load_settings('{hold: '0, fade: 16'd1, resync: '0, magic: '0, version: '0,
                      length: 7'd1});
      random_phase(200);

      load_settings('{hold: '1, fade: '1, resync: '1, magic: '1, version: '1,
                      length: 7'd64});
      random_phase(200);

      c        = short_window_cfg();
      c.hold   = '0;
      c.fade   = '1;
      c.resync = '1;
      load_settings(c);
      random_phase(200);

      c      = short_window_cfg();
      c.fade = '0;
      load_settings(c);
      random_phase(200);

      c        = short_window_cfg();
      c.length = '0;
      load_settings(c);
      random_phase(50);

      load_settings(short_window_cfg());
      random_phase(200);

      drain();
      repeat (40) @(posedge clock);
      $display("Drove %0d ticks and %0d packets under %0d register settings; %0d results compared.",
               ticks_sent, packets_sent, settings_used, results_checked);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
